// ----- sv/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gbac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbac_pkg
// Shared types, codes and constants of the glyph bitmap to ARGB converter.
// ----------------------------------------------------------------------------
package gbac_pkg;

    // field and port widths
    localparam int MODE_W      = 2;
    localparam int ROW_W       = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int WORD_W      = 32;
    localparam int CHAN_W      = 8;
    localparam int NUM_W       = 16;
    localparam int NUM_CHAN    = 3;

    // default for the widest supported bitmap row
    localparam int DEF_MAX_ROW_WIDTH = 4096;

    // source format codes
    localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BGRA = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

    // reset values of the registers
    localparam logic [MODE_W-1:0] RST_SRC_FMT   = MODE_GRAY;
    localparam logic [ROW_W-1:0]  RST_ROW_WIDTH = 13'd1;

    // pixel constants
    localparam logic [23:0]       WHITE_RGB    = 24'hFF_FFFF;
    localparam logic [CHAN_W-1:0] ALPHA_FULL   = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_NONE   = 8'd0;
    localparam logic [2:0]        LAST_BIT_IDX = 3'd7;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV_STEP,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_alpha_partial;
        logic              div_last;
        logic              emit_last;
        logic              out_free;
    } status_t;

endpackage

// ----- sv/gbac_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbac_ctrl
// Sequencer: takes a word, runs the divider when needed, then paces pixels.
// ----------------------------------------------------------------------------
module gbac_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbac_pkg::status_t status,
    output gbac_pkg::cmd_t    cmd
);

    gbac_pkg::state_t state_reg;
    gbac_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbac_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbac_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (status.mode)
                        gbac_pkg::MODE_GRAY: state_next = gbac_pkg::S_EMIT;
                        gbac_pkg::MODE_MONO: state_next = gbac_pkg::S_EMIT;
                        gbac_pkg::MODE_BGRA:
                        begin
                            state_next = status.in_alpha_partial ? gbac_pkg::S_DIV_INIT
                                                                 : gbac_pkg::S_EMIT;
                        end
                        // reserved mode: word dropped
                        default: state_next = gbac_pkg::S_IDLE;
                    endcase
                end
            end
            gbac_pkg::S_DIV_INIT:
            begin
                state_next = gbac_pkg::S_DIV_STEP;
            end
            gbac_pkg::S_DIV_STEP:
            begin
                if (status.div_last)
                begin
                    state_next = gbac_pkg::S_EMIT;
                end
            end
            gbac_pkg::S_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = gbac_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gbac_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready     = (state_reg == gbac_pkg::S_IDLE);
        cmd.load     = (state_reg == gbac_pkg::S_IDLE) && in_valid;
        cmd.div_init = (state_reg == gbac_pkg::S_DIV_INIT);
        cmd.div_step = (state_reg == gbac_pkg::S_DIV_STEP);
        cmd.emit     = (state_reg == gbac_pkg::S_EMIT) && status.out_free;
    end

endmodule

// ----- sv/gbac_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbac_datapath
// Registers, column counter, three-lane restoring divider and output stage.
// ----------------------------------------------------------------------------
module gbac_datapath
#(
    parameter int MAX_ROW_WIDTH = gbac_pkg::DEF_MAX_ROW_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gbac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbac_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [gbac_pkg::WORD_W-1:0]       source_word,
    input  gbac_pkg::cmd_t                    cmd,
    output gbac_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gbac_pkg::WORD_W-1:0]       argb_pixel,
    output logic                              last_of_item,
    output logic                              row_end
);

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int EW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int XW = (EW > gbac_pkg::ROW_W) ? EW : gbac_pkg::ROW_W;
    localparam int C8 = gbac_pkg::CHAN_W;
    localparam int NC = gbac_pkg::NUM_CHAN;
    localparam int NW = gbac_pkg::NUM_W;

    logic [gbac_pkg::MODE_W-1:0] mode_reg;
    logic [gbac_pkg::ROW_W-1:0]  row_width_reg;
    logic [gbac_pkg::WORD_W-1:0] word_reg;
    logic [2:0]                  bit_idx_reg;
    logic [CW-1:0]               col_reg;
    logic [NW-1:0]               num_reg [NC];
    logic [C8-1:0]               rem_reg [NC];
    logic [C8-1:0]               quo_reg [NC];
    logic [NC-1:0]               sat_reg;
    logic [2:0]                  step_reg;
    logic                        out_valid_reg;
    logic [gbac_pkg::WORD_W-1:0] out_pixel_reg;
    logic                        out_last_reg;
    logic                        out_row_end_reg;

    logic [C8-1:0]               in_alpha;
    logic [C8-1:0]               alpha;
    logic                        alpha_partial;
    logic [NW-1:0]               num_in [NC];
    logic [C8:0]                 trial [NC];
    logic                        trial_ge [NC];
    logic [C8-1:0]               chan_out [NC];
    logic [XW-1:0]               rw_ext;
    logic [XW-1:0]               w_eff;
    logic [XW-1:0]               col_plus;
    logic                        row_end_now;
    logic                        mono_bit;
    logic                        pix_last;
    logic [gbac_pkg::WORD_W-1:0] pix;
    logic                        out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= gbac_pkg::RST_SRC_FMT;
            row_width_reg <= gbac_pkg::RST_ROW_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbac_pkg::CFG_SRC_FMT:   mode_reg      <= cfg_data[gbac_pkg::MODE_W-1:0];
                gbac_pkg::CFG_ROW_WIDTH: row_width_reg <= cfg_data[gbac_pkg::ROW_W-1:0];
                default:                 mode_reg      <= mode_reg;
            endcase
        end
    end

    // alpha of the incoming and the held word
    assign in_alpha      = source_word[31:24];
    assign alpha         = word_reg[31:24];
    assign alpha_partial = (alpha != gbac_pkg::ALPHA_NONE) && (alpha != gbac_pkg::ALPHA_FULL);

    // dividend per channel: c*255 + a/2
    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            num_in[ch] = ({source_word[ch*C8 +: C8], {C8{1'b0}}}
                          - {{C8{1'b0}}, source_word[ch*C8 +: C8]})
                         + {{(C8+1){1'b0}}, in_alpha[C8-1:1]};
        end
    end

    // one restoring step per lane
    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            trial[ch]    = {rem_reg[ch], num_reg[ch][step_reg]};
            trial_ge[ch] = (trial[ch] >= {1'b0, alpha});
        end
    end

    // divider lanes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= source_word;
            for (int ch = 0; ch < NC; ch++)
            begin
                num_reg[ch] <= num_in[ch];
            end
        end
        else if (cmd.div_init)
        begin
            for (int ch = 0; ch < NC; ch++)
            begin
                // quotient above 255 when the dividend reaches a*256
                sat_reg[ch] <= (num_reg[ch] >= {alpha, {C8{1'b0}}});
                rem_reg[ch] <= num_reg[ch][NW-1:C8];
            end
        end
        else if (cmd.div_step)
        begin
            for (int ch = 0; ch < NC; ch++)
            begin
                rem_reg[ch]           <= trial_ge[ch] ? C8'(trial[ch] - {1'b0, alpha})
                                                      : trial[ch][C8-1:0];
                quo_reg[ch][step_reg] <= trial_ge[ch];
            end
        end
    end

    // divider bit position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            step_reg <= gbac_pkg::LAST_BIT_IDX;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - 3'd1;
        end
    end

    // effective row width and row end
    assign rw_ext      = XW'(row_width_reg);
    assign w_eff       = (rw_ext == '0) ? XW'(1)
                       : ((rw_ext > XW'(MAX_ROW_WIDTH)) ? XW'(MAX_ROW_WIDTH) : rw_ext);
    assign col_plus    = XW'(col_reg) + XW'(1);
    assign row_end_now = (col_plus >= w_eff);

    // pixel assembly
    assign mono_bit = word_reg[gbac_pkg::LAST_BIT_IDX - bit_idx_reg];
    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            chan_out[ch] = sat_reg[ch] ? gbac_pkg::ALPHA_FULL : quo_reg[ch];
        end
        pix      = word_reg;
        pix_last = 1'b1;
        case (mode_reg)
            gbac_pkg::MODE_GRAY:
            begin
                pix = {word_reg[7:0], gbac_pkg::WHITE_RGB};
            end
            gbac_pkg::MODE_MONO:
            begin
                pix      = {{C8{mono_bit}}, gbac_pkg::WHITE_RGB};
                pix_last = (bit_idx_reg == gbac_pkg::LAST_BIT_IDX) || row_end_now;
            end
            gbac_pkg::MODE_BGRA:
            begin
                if (alpha_partial)
                begin
                    pix = {alpha, chan_out[2], chan_out[1], chan_out[0]};
                end
            end
            default:
            begin
                pix = word_reg;
            end
        endcase
    end

    // column counter and bit position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            bit_idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            bit_idx_reg <= '0;
        end
        else if (cmd.emit)
        begin
            col_reg     <= row_end_now ? '0 : col_plus[CW-1:0];
            bit_idx_reg <= bit_idx_reg + 3'd1;
        end
    end

    // output stage
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_pixel_reg   <= pix;
            out_last_reg    <= pix_last;
            out_row_end_reg <= row_end_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign argb_pixel   = out_pixel_reg;
    assign last_of_item = out_last_reg;
    assign row_end      = out_row_end_reg;

    // status to the controller
    always_comb
    begin
        status.mode             = mode_reg;
        status.in_alpha_partial = (in_alpha != gbac_pkg::ALPHA_NONE)
                                  && (in_alpha != gbac_pkg::ALPHA_FULL);
        status.div_last         = (step_reg == 3'd0);
        status.emit_last        = pix_last;
        status.out_free         = out_free;
    end

endmodule

// ----- sv/glyph_bitmap_to_argb_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_to_argb_converter_core
// Glyph bitmap words in, straight-alpha ARGB8888 pixels out.
// ----------------------------------------------------------------------------
// Takes one source word at a time and delivers its pixels one beat per cycle
// through an output register while the output side does not stall. A BGRA
// word with partial alpha first has its three channels go through an
// eight-step restoring divider, one quotient bit per cycle with the three
// channel lanes in parallel, after a setup state. Write the source format
// (index 0) and row_width (index 1) only while the block is idle; row widths
// of 0 act as 1 and widths above MAX_ROW_WIDTH act as MAX_ROW_WIDTH. With
// source format code 3 a word is taken and dropped.
module glyph_bitmap_to_argb_converter_core
#(
    parameter int MAX_ROW_WIDTH = gbac_pkg::DEF_MAX_ROW_WIDTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbac_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gbac_pkg::WORD_W-1:0]     source_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gbac_pkg::WORD_W-1:0]     argb_pixel,
    output logic                            last_of_item,
    output logic                            row_end
);

    gbac_pkg::cmd_t    cmd;
    gbac_pkg::status_t status;

    // sequencer
    gbac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    gbac_datapath
    #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_word  (source_word),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .argb_pixel   (argb_pixel),
        .last_of_item (last_of_item),
        .row_end      (row_end)
    );

endmodule

// ----- sv/gbac_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbac_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbac_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [gbac_pkg::WORD_W-1:0] argb_pixel,
    input logic                        last_of_item,
    input logic                        row_end
);

    logic [gbac_pkg::WORD_W+1:0] out_beat;

    // output payload as one vector
    assign out_beat = {argb_pixel, last_of_item, row_end};

    // a stalled beat stays
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "beat dropped")

    // a stalled beat keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_beat), "beat changed")

    // a row never ends in the middle of a word's pixels
    `ASSERT_IMPLY(a_row_end_last, clk, rst_n, out_valid && row_end, last_of_item, "early row end")

    // an idle block with nothing pending shows no beat on the next cycle
    `ASSERT_NEXT(a_no_early_beat, clk, rst_n, in_ready && !out_valid, !out_valid, "beat without work")

endmodule

bind glyph_bitmap_to_argb_converter_core gbac_checker u_gbac_checker (.*);

// ----- tb/sv/glyph_bitmap_to_argb_converter_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_to_argb_converter_core_test
// Self-checking bench for the glyph bitmap to ARGB8888 converter.
// ----------------------------------------------------------------------------
// Feeds gray, mono and premultiplied BGRA source words through the valid/ready
// input, predicts every pixel beat with its own model of the unpack,
// un-premultiply and column logic, and checks each output beat in order.
// Directed cases come first, then back-pressure, then random phases with
// random idling on both sides.
module glyph_bitmap_to_argb_converter_core_test;

    // meaningless source format, words are taken and dropped
    localparam logic [gbac_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

    localparam int MAX_COLS       = gbac_pkg::DEF_MAX_ROW_WIDTH;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 30;
    localparam int HOLD_CYCLES    = 200;
    localparam int TIMEOUT_NS     = 1_500_000;

    typedef struct packed {
        logic [gbac_pkg::WORD_W-1:0] argb;
        logic                        last;
        logic                        row_end;
    } pixel_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gbac_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gbac_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [gbac_pkg::WORD_W-1:0]     source_word;
    logic                            out_valid;
    logic                            out_ready;
    logic [gbac_pkg::WORD_W-1:0]     argb_pixel;
    logic                            last_of_item;
    logic                            row_end;

    // predictor state
    logic [gbac_pkg::MODE_W-1:0]     model_mode;
    logic [gbac_pkg::ROW_W-1:0]      model_row_width;
    int                              model_column;

    pixel_beat_t                     expected_pixels[$];
    pixel_beat_t                     head_beat;

    // traffic shaping
    bit                              tx_gaps;
    bit                              rx_stalls;
    int                              rx_hold_len;

    // bookkeeping
    int                              error_count;
    int                              words_sent;
    int                              pixels_checked;
    int                              words_per_mode[4];

    glyph_bitmap_to_argb_converter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_word  (source_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .argb_pixel   (argb_pixel),
        .last_of_item (last_of_item),
        .row_end      (row_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // pixel prediction
    // ------------------------------------------------------------------------

    // row width as the block sees it
    function automatic int active_width();
        int w;
        w = model_row_width;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_COLS)
        begin
            w = MAX_COLS;
        end
        return w;
    endfunction

    // step the column, flag the last pixel of the row
    function automatic logic step_column(input int w);
        if (model_column + 1 >= w)
        begin
            model_column = 0;
            return 1'b1;
        end
        model_column++;
        return 1'b0;
    endfunction

    // straight alpha from premultiplied channel, rounded and clamped
    function automatic logic [gbac_pkg::CHAN_W-1:0] restore_channel(input int c, input int a);
        int v;
        v = (c * 255 + a / 2) / a;
        if (v > 255)
        begin
            v = 255;
        end
        return v[gbac_pkg::CHAN_W-1:0];
    endfunction

    // queue up the pixels one source word turns into
    function automatic void expect_pixels(input logic [gbac_pkg::WORD_W-1:0] w);
        pixel_beat_t beat;
        int          width;
        int          remaining;
        int          count;
        int          a;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        width = active_width();
        case (model_mode)
            gbac_pkg::MODE_GRAY:
            begin
                beat.argb    = {w[7:0], gbac_pkg::WHITE_RGB};
                beat.last    = 1'b1;
                beat.row_end = step_column(width);
                expected_pixels.push_back(beat);
            end
            gbac_pkg::MODE_MONO:
            begin
                remaining = (model_column < width) ? width - model_column : 1;
                count     = (remaining < 8) ? remaining : 8;
                for (int k = 0; k < count; k++)
                begin
                    beat.argb    = {(w[7 - k] ? gbac_pkg::ALPHA_FULL : gbac_pkg::ALPHA_NONE),
                                    gbac_pkg::WHITE_RGB};
                    beat.last    = (k + 1 == count);
                    beat.row_end = step_column(width);
                    expected_pixels.push_back(beat);
                end
            end
            gbac_pkg::MODE_BGRA:
            begin
                a = w[31:24];
                r = w[23:16];
                g = w[15:8];
                b = w[7:0];
                if (a > 0 && a < 255)
                begin
                    r = restore_channel(r, a);
                    g = restore_channel(g, a);
                    b = restore_channel(b, a);
                end
                beat.argb    = {w[31:24], r, g, b};
                beat.last    = 1'b1;
                beat.row_end = step_column(width);
                expected_pixels.push_back(beat);
            end
            default:
            begin
                // word dropped, column untouched
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel beat: argb_pixel %h last_of_item %b row_end %b",
                       argb_pixel, last_of_item, row_end);
                error_count++;
            end
            else
            begin
                head_beat = expected_pixels.pop_front();
                pixels_checked++;
                if (argb_pixel !== head_beat.argb)
                begin
                    $error("argb_pixel: expected %h, actual %h", head_beat.argb, argb_pixel);
                    error_count++;
                end
                if (last_of_item !== head_beat.last)
                begin
                    $error("last_of_item: expected %b, actual %b", head_beat.last, last_of_item);
                    error_count++;
                end
                if (row_end !== head_beat.row_end)
                begin
                    $error("row_end: expected %b, actual %b", head_beat.row_end, row_end);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output ready: random stall bursts, or one long hold when asked
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (rx_hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
                out_ready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender and register helpers, all entered right after a rising edge
    // ------------------------------------------------------------------------

    // offer one source word and hold it until the beat is taken
    task automatic send_word(input logic [gbac_pkg::WORD_W-1:0] w);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        source_word <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expect_pixels(w);
        words_sent++;
        words_per_mode[model_mode]++;
    endtask

    // stop offering and wait until every predicted pixel is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gbac_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [gbac_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == gbac_pkg::CFG_SRC_FMT)
        begin
            model_mode = data[gbac_pkg::MODE_W-1:0];
        end
        else
        begin
            model_row_width = data;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits are junk the mode register drops
    task automatic set_mode(input logic [gbac_pkg::MODE_W-1:0] mode);
        logic [31:0]                     junk;
        logic [gbac_pkg::CFG_DATA_W-1:0] data;
        junk = $urandom;
        data = junk[gbac_pkg::CFG_DATA_W-1:0];
        data[gbac_pkg::MODE_W-1:0] = mode;
        write_reg(gbac_pkg::CFG_SRC_FMT, data);
    endtask

    task automatic set_format(input logic [gbac_pkg::MODE_W-1:0] mode,
                              input logic [gbac_pkg::ROW_W-1:0]  width);
        wait_drained();
        set_mode(mode);
        write_reg(gbac_pkg::CFG_ROW_WIDTH, width);
    endtask

    // premultiplied pixel, mostly well formed, sometimes channels above alpha
    function automatic logic [gbac_pkg::WORD_W-1:0] random_bgra_word();
        logic [7:0] a;
        int         pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            a = 8'd0;
        end
        else if (pick == 1)
        begin
            a = 8'd255;
        end
        else
        begin
            a = 8'($urandom_range(1, 254));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return {a, 24'($urandom)};
        end
        return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                8'($urandom_range(0, a))};
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers at reset values: gray, one pixel per row
    task automatic run_reset_defaults();
        send_word(32'h1234_5680);
        send_word(32'h0000_00FF);
    endtask

    // gray alpha extremes, row width zero acting as one
    task automatic run_gray_directed();
        set_format(gbac_pkg::MODE_GRAY, 13'd0);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        set_format(gbac_pkg::MODE_GRAY, 13'd2);
        send_word(32'h5A5A_5AA5);
    endtask

    // mono unpack cut at row end, full bytes, single pixel rows
    task automatic run_mono_directed();
        set_format(gbac_pkg::MODE_MONO, 13'd3);
        send_word(32'hFFFF_FF5A);
        set_format(gbac_pkg::MODE_MONO, 13'd13);
        send_word(32'h0000_00FF);
        send_word(32'h0000_0001);
        set_format(gbac_pkg::MODE_MONO, 13'd8);
        send_word(32'h0000_0000);
        send_word(32'h0000_0080);
        set_format(gbac_pkg::MODE_MONO, 13'd1);
        send_word(32'h0000_007F);
    endtask

    // alpha zero and full pass through, partial alpha rounds and clamps
    task automatic run_bgra_directed();
        set_format(gbac_pkg::MODE_BGRA, 13'd2);
        send_word(32'h00FF_FFFF);
        send_word(32'hFF12_3456);
        send_word(32'h0101_0101);
        send_word(32'h01FF_0080);
        send_word(32'hFE7F_00FE);
        send_word(32'h8040_2010);
        send_word(32'h7F7F_7F7F);
    endtask

    // mode three drops words and leaves the column alone
    task automatic run_mode_three();
        set_format(gbac_pkg::MODE_GRAY, 13'd4);
        send_word(32'h0000_0011);
        wait_drained();
        set_mode(MODE_NONE);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        wait_drained();
        set_mode(gbac_pkg::MODE_GRAY);
        send_word(32'h0000_0022);
        send_word(32'h0000_0033);
    endtask

    // row shrinks under the column: next pixel closes the row
    task automatic run_shrinking_row();
        set_format(gbac_pkg::MODE_MONO, 13'd10);
        send_word(32'h0000_00C3);
        wait_drained();
        write_reg(gbac_pkg::CFG_ROW_WIDTH, 13'd3);
        send_word(32'h0000_0080);
        set_format(gbac_pkg::MODE_GRAY, 13'd3);
        send_word(32'h0000_0044);
    endtask

    // long output hold while words keep coming, then a full drain
    task automatic run_backpressure();
        set_format(gbac_pkg::MODE_MONO, 13'd64);
        tx_gaps     = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
        begin
            send_word($urandom);
        end
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    // random format and width, then a run of words in that format
    task automatic run_random_phase(input bit last_phase);
        logic [gbac_pkg::MODE_W-1:0] mode;
        logic [gbac_pkg::ROW_W-1:0]  width;
        int                          pick;
        mode = 2'($urandom_range(gbac_pkg::MODE_GRAY, gbac_pkg::MODE_BGRA));
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            width = 13'($urandom_range(1, 16));
        end
        else if (pick < 8)
        begin
            width = 13'($urandom_range(17, 300));
        end
        else if (pick == 8)
        begin
            case ($urandom_range(0, 2))
                0:       width = 13'd0;
                1:       width = 13'(MAX_COLS);
                default: width = 13'h1FFF;
            endcase
        end
        else
        begin
            width = 13'($urandom);
        end
        // now and then a few dropped words first
        if ($urandom_range(0, 3) == 0)
        begin
            set_format(MODE_NONE, width);
            repeat ($urandom_range(1, 4)) send_word($urandom);
            wait_drained();
            set_mode(mode);
        end
        else
        begin
            set_format(mode, width);
        end
        if (last_phase)
        begin
            tx_gaps   = 1'b0;
            rx_stalls = 1'b0;
        end
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            if (mode == gbac_pkg::MODE_BGRA)
            begin
                send_word(random_bgra_word());
            end
            else
            begin
                send_word($urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = gbac_pkg::CFG_SRC_FMT;
        cfg_data        = '0;
        in_valid        = 1'b0;
        source_word     = '0;
        model_mode      = gbac_pkg::RST_SRC_FMT;
        model_row_width = gbac_pkg::RST_ROW_WIDTH;
        model_column    = 0;
        tx_gaps         = 1'b1;
        rx_stalls       = 1'b1;
        rx_hold_len     = 0;
        error_count     = 0;
        words_sent      = 0;
        pixels_checked  = 0;
        for (int m = 0; m < 4; m++)
        begin
            words_per_mode[m] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_reset_defaults();
        run_gray_directed();
        run_mono_directed();
        run_bgra_directed();
        run_mode_three();
        run_shrinking_row();
        run_backpressure();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            run_random_phase(p == RANDOM_PHASES - 1);
        end
        wait_drained();

        $display("covered %0d words (gray %0d, mono %0d, bgra %0d, dropped %0d)",
                 words_sent, words_per_mode[gbac_pkg::MODE_GRAY],
                 words_per_mode[gbac_pkg::MODE_MONO], words_per_mode[gbac_pkg::MODE_BGRA],
                 words_per_mode[MODE_NONE]);
        $display("checked %0d pixel beats, %0d mismatches", pixels_checked, error_count);
        if (error_count == 0 && expected_pixels.size() == 0)
        begin
            $display("PASS glyph_bitmap_to_argb_converter_core");
        end
        else
        begin
            $display("FAIL glyph_bitmap_to_argb_converter_core");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL glyph_bitmap_to_argb_converter_core");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/gbac_pkg.sv
sv/gbac_ctrl.sv
sv/gbac_datapath.sv
sv/glyph_bitmap_to_argb_converter_core.sv
sv/gbac_checker.sv
tb/sv/glyph_bitmap_to_argb_converter_core_test.sv
